[hdl/pspc_pkg.sv]
// pspc_pkg: shared types and constants for the printer stream page counter.
// Parse modes, opcodes, field widths and the result record.
// No dependencies.
package pspc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int BYTE_BITS  = 8;
	localparam int PAGE_BITS  = 16;
	localparam int GLYPH_BITS = 16;
	localparam int SKIP_BITS  = 30;
	localparam int ROWB_BITS  = GLYPH_BITS - 2;

	typedef enum logic [3:0] {
		MODE_SCAN   = 4'd0,
		MODE_SKIP   = 4'd1,
		MODE_MOVE   = 4'd2,
		MODE_SM_W   = 4'd3,
		MODE_SM_H   = 4'd4,
		MODE_BG_WHI = 4'd5,
		MODE_BG_WLO = 4'd6,
		MODE_BG_HHI = 4'd7,
		MODE_BG_HLO = 4'd8
	} mode_t;

	localparam logic [BYTE_BITS-1:0] OP_MOVE   = 8'd130;
	localparam logic [BYTE_BITS-1:0] OP_SGLY   = 8'd198;
	localparam logic [BYTE_BITS-1:0] OP_BGLY   = 8'd199;
	localparam logic [BYTE_BITS-1:0] OP_EPAGE  = 8'd219;
	localparam logic [BYTE_BITS-1:0] OP_2B_A   = 8'd195;
	localparam logic [BYTE_BITS-1:0] OP_2B_B   = 8'd196;
	localparam logic [BYTE_BITS-1:0] OP_2B_C   = 8'd210;
	localparam logic [BYTE_BITS-1:0] OP_2B_D   = 8'd209;
	localparam logic [BYTE_BITS-1:0] OP_2B_E   = 8'd208;
	localparam logic [BYTE_BITS-1:0] OP_2B_F   = 8'd201;
	localparam logic [BYTE_BITS-1:0] OP_1B_A   = 8'd202;
	localparam logic [BYTE_BITS-1:0] OP_1B_B   = 8'd207;
	localparam logic [BYTE_BITS-1:0] OP_3B     = 8'd192;
	localparam logic [BYTE_BITS-1:0] OP_6B     = 8'd193;

	typedef struct packed {
		logic [PAGE_BITS-1:0] pages;
		logic                 page_end;
	} result_t;

endpackage

[hdl/printer_stream_page_counter.sv]
// printer_stream_page_counter: top level; input byte register, parser, result register.
// Depends on pspc_pkg, pspc_parse and pspc_out_reg.
//
// Takes one command-stream byte per cycle while in_ready is high and returns one
// result per byte: the saturating end-of-page count and a flag marking an end-of-page
// opcode. Throughput is one byte every clock cycle with out_ready held high; each byte
// passes the input register, then the result register, before its result is valid.
// The parse step, including the glyph bitmap size multiply, sits between those two
// registers. in_ready drops only when both registers are full and the output stalls.
module printer_stream_page_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pspc_pkg::BYTE_BITS-1:0] data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pspc_pkg::PAGE_BITS-1:0] pages_seen,
	output logic                          page_end
);
	import pspc_pkg::*;

	logic                 v_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 adv;
	result_t              res;

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= data_byte;
	end

	pspc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.data_byte (byte_s1),
		.res       (res)
	);

	pspc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv),
		.res        (res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pages_seen (pages_seen),
		.page_end   (page_end)
	);

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("result register not loaded after parse step");

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && out_valid && !out_ready))
		else $error("input stalled without downstream back-pressure");

endmodule

[hdl/pspc_parse.sv]
// pspc_parse: command syntax tracker and saturating page counter.
// Holds the parse state; produces the result for the byte being consumed.
// Depends on pspc_pkg.
module pspc_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [pspc_pkg::BYTE_BITS-1:0] data_byte,
	output pspc_pkg::result_t             res
);
	import pspc_pkg::*;

	mode_t                  mode_q, mode_d;
	mode_t                  after_q, after_d;
	logic [SKIP_BITS-1:0]   skip_q, skip_d;
	logic [GLYPH_BITS-1:0]  cols_q, cols_d;
	logic [GLYPH_BITS-1:0]  rows_q, rows_d;
	logic [COUNT_BITS-1:0]  total_q, total_d;
	logic                   pend;
	logic [GLYPH_BITS:0]    cols_rnd;
	logic [ROWB_BITS-1:0]   rowbytes;
	logic [GLYPH_BITS-1:0]  rows_src;
	logic [SKIP_BITS-1:0]   bitmap;

	assign cols_rnd = {1'b0, cols_q} + (GLYPH_BITS+1)'(7);
	assign rowbytes = cols_rnd[GLYPH_BITS:3];
	assign rows_src = (mode_q == MODE_BG_HLO) ? {rows_q[GLYPH_BITS-1:BYTE_BITS], data_byte}
	                                           : {{(GLYPH_BITS-BYTE_BITS){1'b0}}, data_byte};
	assign bitmap = SKIP_BITS'(rows_src) * SKIP_BITS'(rowbytes);

	always_comb begin
		mode_d  = mode_q;
		after_d = after_q;
		skip_d  = skip_q;
		cols_d  = cols_q;
		rows_d  = rows_q;
		total_d = total_q;
		pend    = 1'b0;
		unique case (mode_q)
			MODE_SKIP: begin
				if (skip_q <= SKIP_BITS'(1)) begin
					skip_d = '0;
					mode_d = after_q;
				end else begin
					skip_d = skip_q - SKIP_BITS'(1);
				end
			end
			MODE_MOVE: begin
				if (data_byte == OP_MOVE) mode_d = MODE_SCAN;
			end
			MODE_SM_W: begin
				cols_d  = {{(GLYPH_BITS-BYTE_BITS){1'b0}}, data_byte};
				after_d = MODE_SM_H;
				skip_d  = SKIP_BITS'(1);
				mode_d  = MODE_SKIP;
			end
			MODE_SM_H: begin
				rows_d  = rows_src;
				cols_d  = GLYPH_BITS'(rowbytes);
				after_d = MODE_SCAN;
				skip_d  = bitmap + SKIP_BITS'(1);
				mode_d  = MODE_SKIP;
			end
			MODE_BG_WHI: begin
				cols_d = {data_byte, {BYTE_BITS{1'b0}}};
				mode_d = MODE_BG_WLO;
			end
			MODE_BG_WLO: begin
				cols_d  = {cols_q[GLYPH_BITS-1:BYTE_BITS], data_byte};
				after_d = MODE_BG_HHI;
				skip_d  = SKIP_BITS'(2);
				mode_d  = MODE_SKIP;
			end
			MODE_BG_HHI: begin
				rows_d = {data_byte, {BYTE_BITS{1'b0}}};
				mode_d = MODE_BG_HLO;
			end
			MODE_BG_HLO: begin
				rows_d  = rows_src;
				cols_d  = GLYPH_BITS'(rowbytes);
				after_d = MODE_SCAN;
				skip_d  = bitmap + SKIP_BITS'(2);
				mode_d  = MODE_SKIP;
			end
			default: begin
				unique case (data_byte)
					OP_MOVE: mode_d = MODE_MOVE;
					OP_2B_A, OP_2B_B, OP_2B_C, OP_2B_D, OP_2B_E, OP_2B_F: begin
						skip_d = SKIP_BITS'(2);
						mode_d = MODE_SKIP;
					end
					OP_1B_A, OP_1B_B: begin
						skip_d = SKIP_BITS'(1);
						mode_d = MODE_SKIP;
					end
					OP_3B: begin
						skip_d = SKIP_BITS'(3);
						mode_d = MODE_SKIP;
					end
					OP_6B: begin
						skip_d = SKIP_BITS'(6);
						mode_d = MODE_SKIP;
					end
					OP_SGLY: begin
						after_d = MODE_SM_W;
						skip_d  = SKIP_BITS'(3);
						mode_d  = MODE_SKIP;
					end
					OP_BGLY: begin
						after_d = MODE_BG_WHI;
						skip_d  = SKIP_BITS'(4);
						mode_d  = MODE_SKIP;
					end
					OP_EPAGE: begin
						pend = 1'b1;
						if (total_q != '1) total_d = total_q + COUNT_BITS'(1);
					end
					default: ;
				endcase
			end
		endcase
	end

	assign res.pages    = PAGE_BITS'(total_d);
	assign res.page_end = pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SCAN;
			after_q <= MODE_SCAN;
			skip_q  <= '0;
			cols_q  <= '0;
			rows_q  <= '0;
			total_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			after_q <= after_d;
			skip_q  <= skip_d;
			cols_q  <= cols_d;
			rows_q  <= rows_d;
			total_q <= total_d;
		end
	end

endmodule

[hdl/pspc_out_reg.sv]
// pspc_out_reg: result register with valid/ready handshake.
// Loads a result record and holds it until the transaction completes.
// Depends on pspc_pkg.
module pspc_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  pspc_pkg::result_t             res,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pspc_pkg::PAGE_BITS-1:0] pages_seen,
	output logic                          page_end
);
	import pspc_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res;
	end

	assign out_valid  = valid_q;
	assign pages_seen = res_q.pages;
	assign page_end   = res_q.page_end;

endmodule
